/* src/qtable_offset_selector_unit_macros.svh */
// Assertion macros for the Q-table offset selector.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef QTABLE_OFFSET_SELECTOR_UNIT_MACROS_SVH
`define QTABLE_OFFSET_SELECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define QOS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qos: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define QOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qos: next-cycle check failed");
`else
`define QOS_ASSERT_IMP(lbl, ante, cons)
`define QOS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/qos_pkg.sv */
// Shared types and constants for the Q-table offset selector.
// No dependencies; imported by qos_mul and the top level.
`default_nettype none

package qos_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_OFFSETS = 64;
  localparam int TABLE_DEPTH = NUM_STATES * NUM_OFFSETS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int OFS_W       = $clog2(NUM_OFFSETS);
  localparam int CNT_W       = OFS_W + 1;

  // Fixed field widths of the ports.
  localparam int IN_STATE_W = 8;
  localparam int IN_OFS_W   = 6;
  localparam int REWARD_W   = 16;
  localparam int OUT_OFS_W  = 6;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // Datapath widths.
  localparam int Q_W       = 32;
  localparam int GAMMA_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int DIFF_W    = 34;
  localparam int MUL_B_W   = DIFF_W;
  localparam int PROD_W    = GAMMA_W + 1 + MUL_B_W;
  localparam int MUL_RES_W = PROD_W - FRAC_W;
  localparam int NV_W      = MUL_RES_W;

  localparam logic [GAMMA_W-1:0] GAMMA_RST       = 16'd58982;
  localparam logic [Q_W-1:0]     EXPLORE_WIN_RST = 32'd0;
  localparam logic [Q_W-1:0]     INIT_VALUE_RST  = 32'd655360;

  typedef enum logic {
    OP_CHOOSE = 1'b0,
    OP_LEARN  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAMMA          = 2'd0,
    CFG_EXPLORE_WINDOW = 2'd1,
    CFG_INIT_VALUE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LRD2,
    ST_LRD1,
    ST_LDIFF,
    ST_LMUL2,
    ST_LWR
  } fsm_t;

  typedef struct packed {
    logic                      load;
    logic [GAMMA_W-1:0]        gamma;
    logic signed [MUL_B_W-1:0] operand;
  } mul_req_t;

  localparam int RND_LUT_N = 2 ** IN_OFS_W;
  typedef logic [OUT_OFS_W-1:0] rnd_lut_t [RND_LUT_N];

  // Reduction of the random offset into the offset range, as a small table.
  function automatic rnd_lut_t mk_rnd_lut();
    rnd_lut_t lut;
    for (int i = 0; i < RND_LUT_N; i++) begin
      lut[i] = OUT_OFS_W'(i % NUM_OFFSETS);
    end
    return lut;
  endfunction

  localparam rnd_lut_t RND_OFS_LUT = mk_rnd_lut();

endpackage

`default_nettype wire

/* src/qos_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module qos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/qos_mul.sv */
// Shared gamma multiplier with Q16 rounding, used twice per learn request.
// Depends on qos_pkg.
`default_nettype none

module qos_mul (
  input  logic                                    clk,
  input  qos_pkg::mul_req_t                       req,
  output logic signed [qos_pkg::MUL_RES_W-1:0]    res
);
  import qos_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] biased;

  always_comb begin
    prod_nxt = prod_r;
    if (req.load) begin
      prod_nxt = $signed({1'b0, req.gamma}) * req.operand;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Halves round up: floor((p + 2^15) / 2^16).
  assign biased = prod_r + ROUND_BIAS;
  assign res    = MUL_RES_W'(biased >>> FRAC_W);

endmodule

`default_nettype wire

/* src/qtable_offset_selector_unit.sv */
// Q-table offset selector: SARSA update and epsilon-greedy offset choice.
// Depends on qos_pkg, qos_ram, qos_mul and the assertion macro header.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+---------------------------------------------
//   in      | start, busy        | in_operation .. in_random_offset
//   out     | out_valid (strobe) | out_chosen_offset, out_was_random
//   cfg     | cfg_we             | cfg_index, cfg_wdata
//
// An exploring choose request is answered from ST_IDLE; the result strobes in
// the next cycle. A greedy choose scans the row, reading one table entry per
// cycle through the single RAM read port. A learn request steps through the
// states ST_LRD2 to ST_LWR and passes twice through the shared multiplier. After
// reset and after each valid config write the table is refilled, busy held high.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none
`include "qtable_offset_selector_unit_macros.svh"

module qtable_offset_selector_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_operation,
  input  logic [qos_pkg::IN_STATE_W-1:0]         in_state_a,
  input  logic [qos_pkg::IN_OFS_W-1:0]           in_offset_a,
  input  logic signed [qos_pkg::REWARD_W-1:0]    in_reward,
  input  logic [qos_pkg::IN_STATE_W-1:0]         in_state_b,
  input  logic [qos_pkg::IN_OFS_W-1:0]           in_offset_b,
  input  logic                                   in_explore_draw,
  input  logic [qos_pkg::IN_OFS_W-1:0]           in_random_offset,
  output logic                                   out_valid,
  output logic [qos_pkg::OUT_OFS_W-1:0]          out_chosen_offset,
  output logic                                   out_was_random,
  input  logic                                   cfg_we,
  input  logic [qos_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [qos_pkg::CFG_W-1:0]              cfg_wdata
);
  import qos_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(NUM_OFFSETS);

  // Control state.
  fsm_t               state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [Q_W-1:0]     explore_cnt_r, explore_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [GAMMA_W-1:0] gamma_r;
  logic [Q_W-1:0]     explore_win_r;
  logic [Q_W-1:0]     init_value_r;

  // Payload registers.
  logic [OUT_OFS_W-1:0]       out_ofs_r, out_ofs_nxt;
  logic                       out_rnd_r, out_rnd_nxt;
  logic [ADDR_W-1:0]          addr1_r, addr1_nxt;
  logic [ADDR_W-1:0]          addr2_r, addr2_nxt;
  logic [ADDR_W-1:0]          row_r, row_nxt;
  logic signed [REWARD_W-1:0] reward_r, reward_nxt;
  logic signed [Q_W-1:0]      best_r, best_nxt;
  logic [OFS_W-1:0]           best_idx_r, best_idx_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [Q_W-1:0]      q1_r, q1_nxt;

  // RAM and multiplier hookup.
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [Q_W-1:0]              ram_wdata;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [Q_W-1:0]              ram_rdata;
  mul_req_t                    mul_req;
  logic signed [MUL_RES_W-1:0] mul_res;

  // Datapath helpers.
  logic                     accept;
  logic                     cfg_hit;
  logic                     explore_take;
  logic                     sa_ok, sb_ok, oa_ok, ob_ok;
  logic [OFS_W-1:0]         pend_idx;
  logic                     take_new;
  logic signed [DIFF_W-1:0] rew_q, t_q, q1_q;
  logic signed [NV_W-1:0]   nv;
  logic [Q_W-1:0]           nv_sat;

  assign accept  = start && !busy;
  assign cfg_hit = cfg_we && (cfg_index == CFG_GAMMA || cfg_index == CFG_EXPLORE_WINDOW ||
                              cfg_index == CFG_INIT_VALUE);

  assign explore_take = (explore_cnt_r < explore_win_r) || in_explore_draw;
  assign sa_ok = 32'(in_state_a) < 32'(NUM_STATES);
  assign sb_ok = 32'(in_state_b) < 32'(NUM_STATES);
  assign oa_ok = 32'(in_offset_a) < 32'(NUM_OFFSETS);
  assign ob_ok = 32'(in_offset_b) < 32'(NUM_OFFSETS);

  // The entry returned this cycle belongs to the read issued in the previous cycle.
  assign pend_idx = OFS_W'(cnt_r - CNT_W'(1));
  assign take_new = (cnt_r == CNT_W'(1)) || ($signed(ram_rdata) > best_r);

  assign rew_q = {{(DIFF_W - Q_W){reward_r[REWARD_W-1]}}, reward_r, {FRAC_W{1'b0}}};
  assign t_q   = mul_res[DIFF_W-1:0];
  assign q1_q  = {{(DIFF_W - Q_W){ram_rdata[Q_W-1]}}, ram_rdata};
  assign nv    = {{(NV_W - Q_W){q1_r[Q_W-1]}}, q1_r} + mul_res;

  always_comb begin
    nv_sat = nv[Q_W-1:0];
    if (nv[NV_W-1:Q_W-1] != {(NV_W - Q_W + 1){nv[NV_W-1]}}) begin
      nv_sat = nv[NV_W-1] ? {1'b1, {(Q_W - 1){1'b0}}} : {1'b0, {(Q_W - 1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    cnt_nxt         = cnt_r;
    explore_cnt_nxt = explore_cnt_r;
    out_valid_nxt   = 1'b0;
    out_ofs_nxt     = out_ofs_r;
    out_rnd_nxt     = out_rnd_r;
    addr1_nxt       = addr1_r;
    addr2_nxt       = addr2_r;
    row_nxt         = row_r;
    reward_nxt      = reward_r;
    best_nxt        = best_r;
    best_idx_nxt    = best_idx_r;
    diff_nxt        = diff_r;
    q1_nxt          = q1_r;
    ram_we          = 1'b0;
    ram_waddr       = clr_addr_r;
    ram_wdata       = init_value_r;
    ram_raddr       = addr1_r;
    mul_req.load    = 1'b0;
    mul_req.gamma   = gamma_r;
    mul_req.operand = diff_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (op_t'(in_operation) == OP_LEARN) begin
            addr1_nxt  = ADDR_W'(32'(in_state_a) * NUM_OFFSETS + 32'(in_offset_a));
            addr2_nxt  = ADDR_W'(32'(in_state_b) * NUM_OFFSETS + 32'(in_offset_b));
            reward_nxt = in_reward;
            if (sa_ok && sb_ok && oa_ok && ob_ok) begin
              state_nxt = ST_LRD2;
            end
          end else if (explore_take) begin
            out_valid_nxt = 1'b1;
            out_ofs_nxt   = RND_OFS_LUT[in_random_offset];
            out_rnd_nxt   = 1'b1;
            if (explore_cnt_r != {Q_W{1'b1}}) begin
              explore_cnt_nxt = explore_cnt_r + Q_W'(1);
            end
          end else if (!sa_ok) begin
            out_valid_nxt = 1'b1;
            out_ofs_nxt   = '0;
            out_rnd_nxt   = 1'b0;
          end else begin
            row_nxt   = ADDR_W'(32'(in_state_a) * NUM_OFFSETS);
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = row_r + ADDR_W'(cnt_r);
        if (cnt_r != '0 && take_new) begin
          best_nxt     = $signed(ram_rdata);
          best_idx_nxt = pend_idx;
        end
        if (cnt_r == SCAN_END) begin
          out_valid_nxt = 1'b1;
          out_ofs_nxt   = OUT_OFS_W'(take_new ? pend_idx : best_idx_r);
          out_rnd_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_LRD2: begin
        ram_raddr = addr2_r;
        state_nxt = ST_LRD1;
      end
      ST_LRD1: begin
        // Q(s2,o2) is on the read port; scale it by gamma.
        ram_raddr       = addr1_r;
        mul_req.load    = 1'b1;
        mul_req.operand = q1_q;
        state_nxt       = ST_LDIFF;
      end
      ST_LDIFF: begin
        diff_nxt  = rew_q + t_q - q1_q;
        q1_nxt    = $signed(ram_rdata);
        state_nxt = ST_LMUL2;
      end
      ST_LMUL2: begin
        mul_req.load    = 1'b1;
        mul_req.operand = diff_r;
        state_nxt       = ST_LWR;
      end
      ST_LWR: begin
        ram_we    = 1'b1;
        ram_waddr = addr1_r;
        ram_wdata = nv_sat;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Any valid register write restarts the table fill.
    if (cfg_hit) begin
      state_nxt    = ST_CLEAR;
      clr_addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      cnt_r         <= '0;
      explore_cnt_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      cnt_r         <= cnt_nxt;
      explore_cnt_r <= explore_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r       <= GAMMA_RST;
      explore_win_r <= EXPLORE_WIN_RST;
      init_value_r  <= INIT_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAMMA:          gamma_r       <= cfg_wdata[GAMMA_W-1:0];
        CFG_EXPLORE_WINDOW: explore_win_r <= cfg_wdata[Q_W-1:0];
        CFG_INIT_VALUE:     init_value_r  <= cfg_wdata[Q_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_ofs_r  <= out_ofs_nxt;
    out_rnd_r  <= out_rnd_nxt;
    addr1_r    <= addr1_nxt;
    addr2_r    <= addr2_nxt;
    row_r      <= row_nxt;
    reward_r   <= reward_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    diff_r     <= diff_nxt;
    q1_r       <= q1_nxt;
  end

  qos_ram #(
    .WIDTH (Q_W),
    .DEPTH (TABLE_DEPTH)
  ) u_qtable (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qos_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_chosen_offset = out_ofs_r;
  assign out_was_random    = out_rnd_r;

  `QOS_ASSERT_IMP(a_out_has_cause, out_valid, $past(accept) || $past(state_r == ST_SCAN))
  `QOS_ASSERT_IMP(a_scan_no_write, state_r == ST_SCAN, !ram_we)
  `QOS_ASSERT_NXT(a_learn_keeps_count, accept && in_operation == OP_LEARN, explore_cnt_r == $past(explore_cnt_r))
  `QOS_ASSERT_NXT(a_cfg_restarts_fill, cfg_hit, state_r == ST_CLEAR && clr_addr_r == '0)

endmodule

`default_nettype wire

/* bench/qtable_offset_selector_unit_tb.sv */
// Self-checking bench for qtable_offset_selector_unit: directed and random choose/learn
// requests, checked result by result against an in-bench model of the Q-table.
// Depends on qos_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module qtable_offset_selector_unit_tb;
  import qos_pkg::*;

  localparam int     RESET_CYCLES  = 8;
  localparam int     SETTLE_CYCLES = 80;   // longest request (greedy scan) plus margin
  localparam int     DRAIN_CYCLES  = 100;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam int     IDLE_STAGE    = 385;  // requests per idling stage
  localparam int     PRESSURE_AT   = 95;
  localparam longint TIMEOUT_NS    = 30_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;

  typedef struct packed {
    op_t                        op;
    logic [IN_STATE_W-1:0]      state_a;
    logic [IN_OFS_W-1:0]        offset_a;
    logic signed [REWARD_W-1:0] reward;
    logic [IN_STATE_W-1:0]      state_b;
    logic [IN_OFS_W-1:0]        offset_b;
    logic                       explore_draw;
    logic [IN_OFS_W-1:0]        random_offset;
  } request_t;

  typedef struct packed {
    logic [OUT_OFS_W-1:0] chosen_offset;
    logic                 was_random;
  } choice_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    choice_t  want;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [IN_STATE_W-1:0] in_state_a = '0;
  logic [IN_OFS_W-1:0] in_offset_a = '0;
  logic signed [REWARD_W-1:0] in_reward = '0;
  logic [IN_STATE_W-1:0] in_state_b = '0;
  logic [IN_OFS_W-1:0] in_offset_b = '0;
  logic in_explore_draw = 1'b0;
  logic [IN_OFS_W-1:0] in_random_offset = '0;
  logic out_valid;
  logic [OUT_OFS_W-1:0] out_chosen_offset;
  logic out_was_random;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  qtable_offset_selector_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_state_a(in_state_a),
    .in_offset_a(in_offset_a),
    .in_reward(in_reward),
    .in_state_b(in_state_b),
    .in_offset_b(in_offset_b),
    .in_explore_draw(in_explore_draw),
    .in_random_offset(in_random_offset),
    .out_valid(out_valid),
    .out_chosen_offset(out_chosen_offset),
    .out_was_random(out_was_random),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Model state of the block.
  logic signed [Q_W-1:0] q_model [TABLE_DEPTH];
  logic [GAMMA_W-1:0]    gamma_r;
  logic [Q_W-1:0]        explore_window_r;
  logic [Q_W-1:0]        init_r;
  logic [Q_W-1:0]        explore_seen;

  choice_t pending_choices [$];
  int      mismatch_count = 0;
  int      results_seen = 0;
  int      requests_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic void refill_table();
    foreach (q_model[i]) q_model[i] = init_r;
  endfunction

  // Works out what one request does to the model; returns 1 when it yields a choice.
  function automatic logic predict_selection(input request_t r, output choice_t c);
    longint q1, q2, t, diff, delta, nv;
    int i1, i2, base, best;
    c = '0;
    if (r.op == OP_LEARN) begin
      i1 = int'({r.state_a, r.offset_a});
      i2 = int'({r.state_b, r.offset_b});
      q1 = longint'(q_model[i1]);
      q2 = longint'(q_model[i2]);
      // Arithmetic shift of the biased product gives round-half-up.
      t = (longint'(gamma_r) * q2 + 32768) >>> 16;
      diff = longint'($signed(r.reward)) * 65536 + t - q1;
      delta = (longint'(gamma_r) * diff + 32768) >>> 16;
      nv = q1 + delta;
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      q_model[i1] = nv[Q_W-1:0];
      return 1'b0;
    end
    if (explore_seen < explore_window_r || r.explore_draw) begin
      c.chosen_offset = OUT_OFS_W'(r.random_offset % NUM_OFFSETS);
      c.was_random = 1'b1;
      if (explore_seen != '1) explore_seen++;
    end else begin
      base = int'(r.state_a) * NUM_OFFSETS;
      best = 0;
      for (int k = 1; k < NUM_OFFSETS; k++) begin
        if (q_model[base + k] > q_model[base + best]) best = k;
      end
      c.chosen_offset = OUT_OFS_W'(best);
      c.was_random = 1'b0;
    end
    return 1'b1;
  endfunction

  // Results cannot be held off, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    choice_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_choices.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request waiting", results_seen));
      end else begin
        want = pending_choices.pop_front();
        if (out_chosen_offset !== want.chosen_offset) begin
          report_mismatch($sformatf("result %0d chosen_offset %0d, expected %0d",
                                    results_seen, out_chosen_offset, want.chosen_offset));
        end
        if (out_was_random !== want.was_random) begin
          report_mismatch($sformatf("result %0d was_random %0b, expected %0b",
                                    results_seen, out_was_random, want.was_random));
        end
      end
    end
  end

  task automatic issue_request(input request_t r, input logic fixed, input choice_t want);
    choice_t c;
    int idle_pct;
    idle_pct = (requests_sent < IDLE_STAGE) ? 21 : (requests_sent < 2 * IDLE_STAGE) ? 57 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= r.op;
    in_state_a <= r.state_a;
    in_offset_a <= r.offset_a;
    in_reward <= r.reward;
    in_state_b <= r.state_b;
    in_offset_b <= r.offset_b;
    in_explore_draw <= r.explore_draw;
    in_random_offset <= r.random_offset;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (predict_selection(r, c)) pending_choices.push_back(fixed ? want : c);
  endtask

  // Learn requests leave no result behind, so give the block time to finish one.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    logic mapped;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mapped = 1'b1;
    case (idx)
      CFG_GAMMA:          gamma_r = val[GAMMA_W-1:0];
      CFG_EXPLORE_WINDOW: explore_window_r = val;
      CFG_INIT_VALUE:     init_r = val;
      default:            mapped = 1'b0;
    endcase
    if (mapped) refill_table();
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] w,
                           input logic [CFG_W-1:0] iv);
    settle_block();
    write_register(CFG_GAMMA, g);
    write_register(CFG_EXPLORE_WINDOW, w);
    write_register(CFG_INIT_VALUE, iv);
  endtask

  // Most states come from a few hot rows so that learning shapes the greedy picks.
  function automatic logic [IN_STATE_W-1:0] pick_state();
    return ($urandom_range(3) != 0) ? IN_STATE_W'($urandom_range(3)) : IN_STATE_W'($urandom());
  endfunction

  function automatic logic [IN_OFS_W-1:0] pick_offset();
    return ($urandom_range(1) != 0) ? IN_OFS_W'($urandom_range(7)) : IN_OFS_W'($urandom());
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op = ($urandom_range(1) != 0) ? OP_LEARN : OP_CHOOSE;
    r.state_a = pick_state();
    r.offset_a = pick_offset();
    r.state_b = pick_state();
    r.offset_b = pick_offset();
    case ($urandom_range(4))
      0, 1:    r.reward = REWARD_W'(int'($urandom_range(16)) - 8);
      2:       r.reward = REWARD_W'($urandom());
      3:       r.reward = {1'b0, {(REWARD_W-1){1'b1}}};
      default: r.reward = {1'b1, {(REWARD_W-1){1'b0}}};
    endcase
    r.explore_draw = ($urandom_range(3) == 0);
    r.random_offset = IN_OFS_W'($urandom());
    return r;
  endfunction

  task automatic random_burst(input int count);
    choice_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      if (n == PRESSURE_AT) settle_block();
      issue_request(random_request(), 1'b0, none);
    end
  endtask

  function automatic directed_row_t dir_row(input op_t op, input int sa, input int oa,
                                            input int rw, input int sb, input int ob,
                                            input int dr, input int ro, input int fixed,
                                            input int wo, input int wr);
    directed_row_t row;
    row.req.op = op;
    row.req.state_a = IN_STATE_W'(sa);
    row.req.offset_a = IN_OFS_W'(oa);
    row.req.reward = REWARD_W'(rw);
    row.req.state_b = IN_STATE_W'(sb);
    row.req.offset_b = IN_OFS_W'(ob);
    row.req.explore_draw = (dr != 0);
    row.req.random_offset = IN_OFS_W'(ro);
    row.fixed = (fixed != 0);
    row.want.chosen_offset = OUT_OFS_W'(wo);
    row.want.was_random = (wr != 0);
    return row;
  endfunction

  initial begin
    directed_row_t dir_tab [$];
    int waited;

    gamma_r = GAMMA_RST;
    explore_window_r = EXPLORE_WIN_RST;
    init_r = INIT_VALUE_RST;
    explore_seen = '0;
    refill_table();

    // Fixed expectations hold for a freshly cleared table at the reset settings.
    dir_tab.push_back(dir_row(OP_CHOOSE,   0,  0,      0,   0,  0, 0,  0, 1,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE, 255, 63,     -1, 255, 63, 1, 63, 1, 63, 1));
    dir_tab.push_back(dir_row(OP_CHOOSE,   0,  0,      0,   0,  0, 1,  0, 1,  0, 1));
    dir_tab.push_back(dir_row(OP_CHOOSE, 128, 42,  21845, 170, 21, 1, 42, 1, 42, 1));
    dir_tab.push_back(dir_row(OP_CHOOSE, 127, 21, -21846,  85, 42, 1, 21, 1, 21, 1));
    dir_tab.push_back(dir_row(OP_LEARN,    0,  5,  32767, 255, 63, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE,   0,  0,      0,   0,  0, 0, 63, 1,  5, 0));
    dir_tab.push_back(dir_row(OP_LEARN,  255, 63, -32768,   0,  5, 1, 63, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE, 255,  0,      0,   0,  0, 0,  0, 1,  0, 0));
    // Repeated maximal and minimal rewards drive entries into saturation.
    dir_tab.push_back(dir_row(OP_LEARN,    0,  5,  32767,   0,  5, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,    0,  5,  32767,   0,  5, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE,   0,  0,      0,   0,  0, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,  255, 63, -32768, 255, 63, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,  255, 63, -32768, 255, 63, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,  255,  0, -32768, 255, 63, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE, 255,  0,      0,   0,  0, 0,  0, 0,  0, 0));
    // Two equal updates in one row: the lower offset must win the tie.
    dir_tab.push_back(dir_row(OP_LEARN,    1,  9,      5,   2,  0, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,    1,  3,      5,   2,  0, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE,   1, 63,     -1, 255, 63, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,    2,  0,      0,   2,  0, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE,   2,  0,      0,   0,  0, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_LEARN,  255, 63,     -1,   0,  0, 1, 63, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE, 170,  0,      0,   0,  0, 0,  0, 0,  0, 0));
    dir_tab.push_back(dir_row(OP_CHOOSE,  85, 21,  21845, 170, 42, 1, 21, 0,  0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // The table is cleared after reset with busy held high.
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    foreach (dir_tab[i]) issue_request(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);
    random_burst(170);

    configure(32'h0000_FFFF, 32'd0, 32'h7FFF_FFFF);
    random_burst(190);
    configure(32'd0, explore_seen + 32'd40, 32'h8000_0000);
    random_burst(190);
    configure(32'd32768, 32'd0, 32'd0);
    write_register(CFG_IDX_UNMAPPED, $urandom());
    random_burst(190);
    configure($urandom(), 32'hFFFF_FFFF, $urandom());
    random_burst(190);
    configure(32'd58982, 32'd0, 32'd655360);
    random_burst(190);

    start <= 1'b0;
    waited = 0;
    while (pending_choices.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_choices.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_choices.size()));
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
